### src/sprite_particle_table_update_top_macros.svh
// assertion macros for the particle table block
// used by sprite_particle_table_update_top
`ifndef SPRITE_PARTICLE_TABLE_UPDATE_TOP_MACROS_SVH
`define SPRITE_PARTICLE_TABLE_UPDATE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define SPT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPT_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPT_ASSERT(label, clk, rst, prop, msg)
`define SPT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### src/spt_pkg.sv
`timescale 1ns / 1ps
// types and constants of the particle table block
// no dependencies
package spt_pkg;
   typedef enum logic [1:0] {
      KIND_SPRITE = 2'd0,
      KIND_TILE   = 2'd1,
      KIND_END    = 2'd2,
      KIND_FULL   = 2'd3
   } kind_type;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_CHK,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_TICK_OUT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  command;
      logic [31:0]           motion_x_word;
      logic [31:0]           motion_y_word;
      logic [11:0]           style_word;
      logic signed [15:0]    camera_x;
      logic signed [15:0]    camera_y;
      logic [6:0]            start_count;
   } req_type;

   typedef struct packed {
      kind_type      kind;
      logic [4:0]    slot;
      logic [11:0]   frame_index;
      logic [15:0]   attr_zero;
      logic [15:0]   attr_one;
      logic [15:0]   attr_two;
      logic [7:0]    sprite_number;
      logic          last;
   } rsp_type;

   localparam int signed ScreenLo = -8;
   localparam int signed ScreenXHi = 240;
   localparam int signed ScreenYHi = 160;
endpackage

### src/spt_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the particle table block
// depends on spt_pkg
interface spt_req_if;
   import spt_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface spt_rsp_if;
   import spt_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface spt_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/sprite_particle_table_update_top.sv
`timescale 1ns / 1ps
// particle table: an add reads and checks the slots in turn (ST_ADD_RD, ST_ADD_CHK) for a free one
// a tick reads and checks each slot (ST_TICK_RD, ST_TICK_CHK), then emits none, one or two results
// via ST_TICK_OUT and ST_EMIT; one word at a time, and a stalled output holds the block
// reset is synchronous: a clearing pass writes zero to every slot, during which
// no word is accepted. tile_base resets to zero.
// depends on spt_pkg, spt_if and the macros header
`include "sprite_particle_table_update_top_macros.svh"
module sprite_particle_table_update_top #(
   parameter int unsigned SLOTS = 16
) (
   input logic      clock,
   input logic      reset,
   spt_req_if.sink  req,
   spt_rsp_if.source rsp,
   spt_csr_if.sink  csr
);
   import spt_pkg::*;

   localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // slot memory: x word, y word, style
   logic [75:0] mem [SLOTS];
   logic [75:0] rd_ff;
   logic        we;
   logic [IdxW-1:0] waddr, raddr;
   logic [75:0] wdata;

   state_type state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic        clr_ff, clr_in;
   req_type     cmd_ff;
   logic [9:0]  tile_base_ff;
   logic [7:0]  count_ff, count_in;
   // pending results: up to two per slot
   rsp_type     p0_ff, p1_ff, p0_in, p1_in;
   logic        p0v_ff, p1v_ff, p0v_in, p1v_in;
   state_type   ret_ff, ret_in;
   rsp_type     out_ff;
   logic        outv_ff;

   // memory
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // configuration
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) tile_base_ff <= '0;
      else if (csr.valid) tile_base_ff <= csr.data;
   end

   wire last_idx = (idx_ff == IdxW'(SLOTS - 1));
   assign req.ready = !clr_ff && state_ff == ST_IDLE;

   // slot fields from the read word
   logic [31:0] wx, wy, nwx, nwy;
   logic [11:0] st;
   logic        free_s, reload;
   logic [15:0] xp, yp;
   logic signed [8:0] vy;
   logic signed [17:0] sx, sy;
   logic        offx, offy;
   logic [9:0]  tile;
   logic [11:0] frm;
   logic [IdxW:0] tri_off;

   always_comb begin
      wx = rd_ff[75:44];
      wy = rd_ff[43:12];
      st = rd_ff[11:0];
      free_s = (wx[31:28] == 4'd0) && (wy[31:30] == 2'd0);
      reload = (wx[31:28] == 4'd0) && !free_s;
      nwx = wx;
      nwy = wy;
      if (reload) begin
         nwy[31:30] = wy[31:30] - 2'd1;
         nwx[31:28] = wx[27:24];
      end
      frm = 12'(({10'd0, nwy[31:30]} + {4'd0, st[7:0]}) << 3);
      nwx[31:28] = nwx[31:28] - 4'd1;
      xp = nwx[15:0] + {{8{nwx[23]}}, nwx[23:16]};
      nwx[15:0] = xp;
      sx = 18'($signed({6'd0, xp[15:4]})) - 18'(cmd_ff.camera_x);
      offx = (sx < 18'(ScreenLo)) || (sx > 18'(ScreenXHi));
      vy = 9'($signed(nwy[23:16])) + (st[8] ? 9'sd1 : 9'sd0)
         - (st[9] ? 9'sd2 : 9'sd0);
      yp = nwy[15:0] + {{7{vy[8]}}, vy};
      nwy[23:16] = vy[7:0];
      nwy[15:0] = yp;
      sy = 18'($signed({6'd0, yp[15:4]})) - 18'(cmd_ff.camera_y);
      offy = (sy < 18'(ScreenLo)) || (sy > 18'(ScreenYHi));
      if (offx) nwy = wy;
      if (reload) begin
         if (offx) begin
            nwy[31:30] = wy[31:30] - 2'd1;
         end
      end
      if (offx || offy) nwx[31:28] = 4'd0;
      tri_off = (IdxW + 1)'(({1'b0, idx_ff} * 3) >> 1);
      tile = 10'(tile_base_ff + 10'(tri_off));
   end

   // next state and memory control
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      clr_in = clr_ff;
      count_in = count_ff;
      p0_in = p0_ff; p1_in = p1_ff; p0v_in = p0v_ff; p1v_in = p1v_ff;
      ret_in = ret_ff;
      we = 1'b0; waddr = idx_ff; wdata = '0; raddr = idx_ff;
      if (clr_ff) begin
         we = 1'b1;
         if (last_idx) begin clr_in = 1'b0; idx_in = '0; end
         else idx_in = idx_ff + 1'b1;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               idx_in = '0;
               raddr = '0;
               if (req.valid) begin
                  count_in = {1'b0, req.data.start_count};
                  state_in = (req.data.command == CMD_ADD) ? ST_ADD_RD : ST_TICK_RD;
               end
            end
            ST_ADD_RD, ST_TICK_RD: begin
               state_in = (state_ff == ST_ADD_RD) ? ST_ADD_CHK : ST_TICK_CHK;
            end
            ST_ADD_CHK: begin
               p0_in = '0;
               p0_in.last = 1'b1;
               p0v_in = 1'b1;
               p1v_in = 1'b0;
               ret_in = ST_IDLE;
               if (free_s) begin
                  we = 1'b1;
                  wdata = {cmd_ff.motion_x_word, cmd_ff.motion_y_word, cmd_ff.style_word};
                  p0_in.kind = KIND_TILE;
                  p0_in.slot = 5'(idx_ff);
                  p0_in.frame_index = 12'(({10'd0, cmd_ff.motion_y_word[31:30]}
                                           + {4'd0, cmd_ff.style_word[7:0]}) << 3);
                  state_in = ST_EMIT;
               end else if (last_idx) begin
                  p0_in.kind = KIND_FULL;
                  state_in = ST_EMIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  raddr = idx_in;
                  state_in = ST_ADD_RD;
               end
            end
            ST_TICK_CHK: begin
               p0v_in = 1'b0; p1v_in = 1'b0;
               p0_in = '0; p1_in = '0;
               if (!free_s) begin
                  we = 1'b1;
                  wdata = {nwx, nwy, st};
                  if (reload) begin
                     p0v_in = 1'b1;
                     p0_in.kind = KIND_TILE;
                     p0_in.slot = 5'(idx_ff);
                     p0_in.frame_index = frm;
                  end
                  if (!offx && !offy) begin
                     p1v_in = 1'b1;
                     p1_in.kind = KIND_SPRITE;
                     p1_in.slot = 5'(idx_ff);
                     p1_in.attr_zero = {8'd0, sy[7:0]};
                     p1_in.attr_one = {2'b0, st[11:10], 3'b0, sx[8:0]};
                     p1_in.attr_two = {nwy[27:24], nwy[29:28], tile};
                     p1_in.sprite_number = count_ff;
                     count_in = count_ff + 8'd1;
                  end
               end
               state_in = ST_TICK_OUT;
            end
            ST_TICK_OUT: begin
               // queue holds this slot's results; then next slot or end marker
               if (!p0v_ff && !p1v_ff) begin
                  if (last_idx) begin
                     p0v_in = 1'b1;
                     p0_in = '0;
                     p0_in.kind = KIND_END;
                     p0_in.last = 1'b1;
                     ret_in = ST_IDLE;
                     state_in = ST_EMIT;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                     raddr = idx_in;
                     state_in = ST_TICK_RD;
                  end
               end else begin
                  ret_in = ST_TICK_OUT;
                  state_in = ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!outv_ff || rsp.ready) begin
                  if (p0v_ff) p0v_in = 1'b0;
                  else p1v_in = 1'b0;
                  if ((p0v_ff && !p1v_ff) || !p0v_ff) state_in = ret_ff;
               end
               raddr = idx_ff;
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         clr_ff <= 1'b1;
         p0v_ff <= 1'b0;
         p1v_ff <= 1'b0;
         outv_ff <= 1'b0;
         ret_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         clr_ff <= clr_in;
         p0v_ff <= p0v_in;
         p1v_ff <= p1v_in;
         ret_ff <= ret_in;
         if (state_ff == ST_EMIT && !clr_ff && (!outv_ff || rsp.ready)) outv_ff <= 1'b1;
         else if (rsp.ready) outv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      if (req.valid && req.ready) cmd_ff <= req.data;
      if (state_ff == ST_EMIT && (!outv_ff || rsp.ready))
         out_ff <= p0v_ff ? p0_ff : p1_ff;
   end

   assign rsp.valid = outv_ff;
   assign rsp.data = out_ff;

   `SPT_ASSERT(a_no_accept_busy, clock, reset, (req.valid && req.ready) |-> state_ff == ST_IDLE, "accept while busy")
   `SPT_ASSERT(a_emit_has_item, clock, reset, (state_ff == ST_EMIT) |-> (p0v_ff || p1v_ff), "emit with empty queue")
   `SPT_ASSERT(a_no_write_idle, clock, reset, (!clr_ff && state_ff == ST_IDLE) |-> !we, "memory write while idle")
   `SPT_ASSERT_RST(a_reset_clears, clock, $past(reset) |-> (clr_ff && !outv_ff), "reset did not start clear")
endmodule

### test/spt_tb_if.sv
`timescale 1ns / 1ps
// testbench constants: table size and largest tile base; no channels of its own
// depends on spt_pkg
package spt_tb_pkg;
   import spt_pkg::*;
   localparam int unsigned TbSlots = 16;
   localparam logic [9:0] TileBaseMax = 10'h3FF;
endpackage

### test/tb_top.sv
`timescale 1ns / 1ps
// testbench of the particle table block: directed and random add/tick words
// checked against a behavioral copy of the slot table; depends on spt_pkg, spt_tb_pkg, spt_if
module tb_top;
   import spt_pkg::*;
   import spt_tb_pkg::*;

   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spt_req_if req ();
   spt_rsp_if rsp ();
   spt_csr_if csr ();

   sprite_particle_table_update_top #(.SLOTS(TbSlots)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [31:0] slot_x [TbSlots];
   logic [31:0] slot_y [TbSlots];
   logic [11:0] slot_style [TbSlots];
   logic [9:0]  tile_base_q;
   rsp_type     expected_words [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          long_hold = 1'b0;

   function automatic logic [11:0] tile_frame(int s);
      logic [11:0] f;
      f = 12'(({10'd0, slot_y[s][31:30]} + {4'd0, slot_style[s][7:0]}) << 3);
      return f;
   endfunction

   function automatic rsp_type blank_word(kind_type k, int s);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.slot = 5'(s);
      return r;
   endfunction

   // table update as seen from outside
   task automatic predict_table(input req_type w);
      rsp_type r;
      int s, fs, sx, sy, vel, cnt;
      logic [31:0] wx, wy;
      logic [11:0] st;
      logic [15:0] x, y;
      if (w.command == CMD_ADD) begin
         fs = -1;
         for (s = 0; s < TbSlots; s++)
            if (fs < 0 && slot_x[s][31:28] == 0 && slot_y[s][31:30] == 0) fs = s;
         if (fs < 0) r = blank_word(KIND_FULL, 0);
         else begin
            slot_x[fs] = w.motion_x_word;
            slot_y[fs] = w.motion_y_word;
            slot_style[fs] = w.style_word;
            r = blank_word(KIND_TILE, fs);
            r.frame_index = tile_frame(fs);
         end
         r.last = 1'b1;
         expected_words.push_back(r);
         return;
      end
      cnt = w.start_count;
      for (s = 0; s < TbSlots; s++) begin
         wx = slot_x[s];
         wy = slot_y[s];
         st = slot_style[s];
         if (wx[31:28] == 0) begin
            if (wy[31:30] == 0) continue;
            wy[31:30] = wy[31:30] - 2'd1;
            wx[31:28] = wx[27:24];
            slot_x[s] = wx;
            slot_y[s] = wy;
            r = blank_word(KIND_TILE, s);
            r.frame_index = tile_frame(s);
            expected_words.push_back(r);
         end
         wx[31:28] = wx[31:28] - 4'd1;
         vel = $signed(wx[23:16]);
         x = 16'(int'(wx[15:0]) + vel);
         wx[15:0] = x;
         sx = int'(x[15:4]) - int'(w.camera_x);
         if (sx < ScreenLo || sx > ScreenXHi) begin
            wx[31:28] = 4'd0;
            slot_x[s] = wx;
            continue;
         end
         slot_x[s] = wx;
         vel = $signed(wy[23:16]);
         if (st[8]) vel += 1;
         if (st[9]) vel -= 2;
         y = 16'(int'(wy[15:0]) + vel);
         wy[23:16] = 8'(vel);
         wy[15:0] = y;
         slot_y[s] = wy;
         sy = int'(y[15:4]) - int'(w.camera_y);
         if (sy < ScreenLo || sy > ScreenYHi) begin
            slot_x[s][31:28] = 4'd0;
            continue;
         end
         r = blank_word(KIND_SPRITE, s);
         r.attr_zero = {8'd0, 8'(sy)};
         r.attr_one = {2'd0, st[11:10], 3'd0, 9'(sx)};
         r.attr_two = {wy[27:24], wy[29:28], 10'(tile_base_q + 10'((s * 3) >> 1))};
         r.sprite_number = 8'(cnt);
         cnt++;
         expected_words.push_back(r);
      end
      r = blank_word(KIND_END, 0);
      r.last = 1'b1;
      expected_words.push_back(r);
   endtask

   // send one word, with random gaps between bursts; valid stays up inside a burst
   int burst_left = 0;
   task automatic send_word(input req_type w);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
      burst_left--;
      req.valid <= 1'b1;
      req.data <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_table(w);
      @(negedge clock);
   endtask

   task automatic write_tile_base(input logic [9:0] v);
      req.valid <= 1'b0;
      csr.valid <= 1'b1;
      csr.data <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      tile_base_q = v;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic drain_all();
      req.valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic req_type add_word(logic [31:0] mx, logic [31:0] my, logic [11:0] sw);
      req_type w;
      w = '0;
      w.command = CMD_ADD;
      w.motion_x_word = mx;
      w.motion_y_word = my;
      w.style_word = sw;
      w.camera_x = 16'($urandom);
      w.camera_y = 16'($urandom);
      w.start_count = 7'($urandom);
      return w;
   endfunction

   function automatic req_type tick_word(logic [15:0] cx, logic [15:0] cy, logic [6:0] sc);
      req_type w;
      w = '0;
      w.command = CMD_TICK;
      w.motion_x_word = $urandom;
      w.motion_y_word = $urandom;
      w.style_word = 12'($urandom);
      w.camera_x = cx;
      w.camera_y = cy;
      w.start_count = sc;
      return w;
   endfunction

   // particle that stays mostly on screen around a camera at the origin
   function automatic req_type live_particle();
      logic [31:0] mx, my;
      mx = {4'($urandom), 4'($urandom), 8'($urandom_range(0, 255)),
            16'($urandom_range(0, 240 * 16))};
      my = {2'($urandom), 2'($urandom), 4'($urandom), 8'($urandom),
            16'($urandom_range(0, 160 * 16))};
      if ($urandom_range(0, 3) != 0) mx[23:16] = 8'($signed(5'($urandom)));
      if ($urandom_range(0, 3) != 0) my[23:16] = 8'($signed(5'($urandom)));
      return add_word(mx, my, 12'($urandom));
   endfunction

   task automatic test_directed();
      write_tile_base(10'd0);
      send_word(tick_word(16'd0, 16'd0, 7'd0));
      // an empty particle keeps its slot free
      send_word(add_word(32'd0, 32'd0, 12'd0));
      send_word(add_word(32'hF0FF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
      // expired life with a frame left and a zero default life
      send_word(add_word(32'h0000_0100, 32'h4000_0100, 12'h300));
      send_word(add_word(32'h1F7F_0000, 32'h8F80_0000, 12'h1FF));
      send_word(add_word(32'h2380_FFFF, 32'h7C7F_FFFF, 12'hE80));
      send_word(tick_word(16'h8000, 16'h7FFF, 7'h7F));
      send_word(tick_word(16'h7FFF, 16'h8000, 7'h00));
      send_word(tick_word(16'hFFF8, 16'hFFF8, 7'h55));
      // fill the table until it reports full
      repeat (18) send_word(add_word(32'h5000_0800, 32'h0000_0800, 12'h200));
      send_word(tick_word(16'd0, 16'd0, 7'h2A));
      drain_all();
      write_tile_base(TileBaseMax);
      send_word(tick_word(16'd0, 16'd0, 7'h7F));
      drain_all();
   endtask

   task automatic test_random(input int count);
      req_type w;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: w = add_word($urandom, $urandom, 12'($urandom));
            1: w = tick_word(16'($urandom), 16'($urandom), 7'($urandom));
            2, 3, 4: w = tick_word(16'($urandom_range(0, 20)) - 16'd10,
                                   16'($urandom_range(0, 20)) - 16'd10, 7'($urandom));
            default: w = live_particle();
         endcase
         send_word(w);
      end
   endtask

   task automatic test_backpressure();
      long_hold = 1'b1;
      for (int i = 0; i < 8; i++) begin
         send_word(live_particle());
         send_word(tick_word(16'd0, 16'd0, 7'($urandom)));
      end
      drain_all();
   endtask

   // receiver: stall pattern plus one long hold-off
   int stall_phase = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (long_hold) begin
         rsp.ready <= 1'b0;
         if (hold_left == 0) hold_left = 400;
         else if (hold_left == 1) begin
            long_hold = 1'b0;
            hold_left = 0;
         end else hold_left--;
      end else begin
         stall_phase = (stall_phase + 1) % 64;
         rsp.ready <= (stall_phase < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // check each result word against the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      cycle_count++;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word kind=%0d slot=%0d", rsp.data.kind, rsp.data.slot);
            fail_count++;
         end else begin
            e = expected_words.pop_front();
            if (rsp.data !== e) begin
               fail_count++;
               if (rsp.data.kind !== e.kind)
                  $error("kind exp %0d got %0d", e.kind, rsp.data.kind);
               if (rsp.data.slot !== e.slot)
                  $error("slot exp %0d got %0d", e.slot, rsp.data.slot);
               if (rsp.data.frame_index !== e.frame_index)
                  $error("frame_index exp %0h got %0h", e.frame_index, rsp.data.frame_index);
               if (rsp.data.attr_zero !== e.attr_zero)
                  $error("attr_zero exp %0h got %0h", e.attr_zero, rsp.data.attr_zero);
               if (rsp.data.attr_one !== e.attr_one)
                  $error("attr_one exp %0h got %0h", e.attr_one, rsp.data.attr_one);
               if (rsp.data.attr_two !== e.attr_two)
                  $error("attr_two exp %0h got %0h", e.attr_two, rsp.data.attr_two);
               if (rsp.data.sprite_number !== e.sprite_number)
                  $error("sprite_number exp %0d got %0d", e.sprite_number,
                         rsp.data.sprite_number);
               if (rsp.data.last !== e.last)
                  $error("last exp %0d got %0d", e.last, rsp.data.last);
            end
         end
      end
      if (cycle_count == CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < TbSlots; s++) begin
         slot_x[s] = '0;
         slot_y[s] = '0;
         slot_style[s] = '0;
      end
      tile_base_q = '0;
      req.valid = 1'b0;
      req.data = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      rsp.ready = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(150);
      drain_all();
      write_tile_base(10'd517);
      test_backpressure();
      test_random(160);
      drain_all();
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

### files.f
+incdir+src
src/spt_pkg.sv
src/spt_if.sv
src/sprite_particle_table_update_top.sv
test/spt_tb_if.sv
test/tb_top.sv
